// ----- design/wrcd_pkg.sv -----
// Package for the window ratio change detector.
// Holds default sizes, register reset values, register indexes and shared types.
// No dependencies.
package wrcd_pkg;

  localparam int WINDOW_LEN_DEF  = 20;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_W  = 8;
  localparam int HOLD_W = 9;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0] TOLERANCE_RESET = 8'd2;
  localparam logic [CFG_W-1:0] HOLDOFF_RESET   = 8'd40;

  typedef enum logic {
    REG_TOLERANCE = 1'b0,
    REG_HOLDOFF   = 1'b1
  } wrcd_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] tolerance;
    logic [CFG_W-1:0] holdoff_items;
  } wrcd_cfg_t;

  typedef struct packed {
    logic load;
    logic full;
  } wrcd_ctl_t;

endpackage

// ----- design/wrcd_cell.sv -----
// One cell of the sample window chain.
// Holds one sample and hands it to the next cell on every shift.
module wrcd_cell #(
  parameter int W = wrcd_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- design/wrcd_eval.sv -----
// Ratio test, holdoff counter and pan direction for the change detector.
// Depends on wrcd_pkg for the configuration and control structs.
module wrcd_eval #(
  parameter int SUM_W = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wrcd_pkg::wrcd_ctl_t       ctl,
  input  wrcd_pkg::wrcd_cfg_t       cfg,
  input  logic [SUM_W-1:0]          older_sum,
  input  logic [SUM_W-1:0]          newer_sum,
  output logic                      toggled,
  output logic                      direction,
  output logic                      evaluated
);
  import wrcd_pkg::*;

  localparam int PROD_W = SUM_W + CFG_W;

  logic [HOLD_W-1:0] holdoff_count;
  logic [HOLD_W-1:0] holdoff_count_next;
  logic              direction_next;
  logic              toggled_next;
  logic              evaluated_next;
  logic              hold_active;
  logic [PROD_W-1:0] prod_old;
  logic [PROD_W-1:0] prod_new;
  logic              ratio_hit;

  assign prod_old = PROD_W'(cfg.tolerance) * PROD_W'(older_sum);
  assign prod_new = PROD_W'(newer_sum) * PROD_W'(cfg.tolerance);
  assign ratio_hit = (PROD_W'(newer_sum) >= prod_old) || (prod_new <= PROD_W'(older_sum));
  assign hold_active = (holdoff_count != '0) &&
                       (holdoff_count <= HOLD_W'(cfg.holdoff_items));

  always_comb begin
    holdoff_count_next = holdoff_count;
    direction_next     = direction;
    toggled_next       = 1'b0;
    evaluated_next     = 1'b0;
    if (ctl.full) begin
      if (hold_active) begin
        holdoff_count_next = holdoff_count + HOLD_W'(1);
      end else begin
        holdoff_count_next = '0;
        evaluated_next     = 1'b1;
        if (ratio_hit) begin
          direction_next     = ~direction;
          toggled_next       = 1'b1;
          holdoff_count_next = HOLD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_count <= '0;
      direction     <= 1'b0;
    end else if (ctl.load) begin
      holdoff_count <= holdoff_count_next;
      direction     <= direction_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      toggled   <= toggled_next;
      evaluated <= evaluated_next;
    end
  end

`ifndef SYNTHESIS
  a_dir_follows_toggle: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> ((direction != $past(direction)) == toggled))
    else $error("Direction changed without a toggle or missed one.");

  a_no_eval_before_full: assert property (@(posedge clk) disable iff (rst)
    ctl.load && !ctl.full |=> !evaluated && !toggled)
    else $error("Evaluation took place before the window was full.");

  a_toggle_needs_eval: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (!toggled || evaluated))
    else $error("Toggle reported without an evaluation.");
`endif

endmodule

// ----- design/window_ratio_change_detector.sv -----
// Window ratio change detector, top level.
// Accepted samples update the half-sums (s1); the ratio result is registered at the output.
// Throughput: one transaction per cycle unless out_ready stalls; the sample chain and running
// half-sums advance once per accepted sample and the ratio test fits in the output stage.
// Reset (synchronous): window, sums, counters and direction cleared, tolerance 2, holdoff 40.
// Depends on wrcd_pkg, wrcd_cell and wrcd_eval.
module window_ratio_change_detector #(
  parameter int WINDOW_LEN  = wrcd_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = wrcd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          toggled,
  output logic                          direction,
  output logic                          evaluated,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [wrcd_pkg::DATA_W-1:0]   pwdata,
  output logic [wrcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import wrcd_pkg::*;

  localparam int HALF   = WINDOW_LEN / 2;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(HALF + 1);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  wrcd_cfg_t cfg;
  wrcd_ctl_t ctl;

  logic [SAMPLE_BITS-1:0] chain [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0] newer_in;
  logic [SUM_W-1:0]       older_sum;
  logic [SUM_W-1:0]       newer_sum;
  logic [FILL_W-1:0]      fill_count;
  logic [FILL_W-1:0]      fill_count_next;
  logic                   s1_valid;
  logic                   s1_full;
  logic                   in_take;
  logic                   out_load;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance     <= TOLERANCE_RESET;
      cfg.holdoff_items <= HOLDOFF_RESET;
    end else if (cfg_write) begin
      unique case (wrcd_reg_t'(paddr[2]))
        REG_TOLERANCE: cfg.tolerance     <= pwdata[CFG_W-1:0];
        REG_HOLDOFF:   cfg.holdoff_items <= pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (wrcd_reg_t'(paddr[2]))
      REG_TOLERANCE: prdata = DATA_W'(cfg.tolerance);
      REG_HOLDOFF:   prdata = DATA_W'(cfg.holdoff_items);
      default:       prdata = '0;
    endcase
  end

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_take  = in_valid && in_ready;

  // Cell k holds the sample of age k; cell 0 takes the newest one.
  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      wrcd_cell #(.W(SAMPLE_BITS)) u_cell (
        .clk(clk), .rst(rst), .shift(in_take), .d(sample), .q(chain[k])
      );
    end else begin : g_body
      wrcd_cell #(.W(SAMPLE_BITS)) u_cell (
        .clk(clk), .rst(rst), .shift(in_take), .d(chain[k-1]), .q(chain[k])
      );
    end
  end

  if (WINDOW_LEN == 2 * HALF) begin : g_even
    assign newer_in = sample;
  end else begin : g_odd
    assign newer_in = chain[WINDOW_LEN-2*HALF-1];
  end

  assign fill_count_next = (fill_count == FILL_W'(WINDOW_LEN)) ?
                           fill_count : fill_count + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sum  <= '0;
      newer_sum  <= '0;
      fill_count <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        older_sum  <= older_sum + SUM_W'(chain[WINDOW_LEN-HALF-1])
                      - SUM_W'(chain[WINDOW_LEN-1]);
        newer_sum  <= newer_sum + SUM_W'(newer_in)
                      - SUM_W'(chain[WINDOW_LEN-HALF-1]);
        fill_count <= fill_count_next;
        s1_valid   <= 1'b1;
      end else if (out_load) begin
        s1_valid   <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_full <= (fill_count_next == FILL_W'(WINDOW_LEN));
    end
  end

  assign ctl.load = out_load;
  assign ctl.full = s1_full;

  wrcd_eval #(.SUM_W(SUM_W)) u_eval (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .cfg(cfg),
    .older_sum(older_sum),
    .newer_sum(newer_sum),
    .toggled(toggled),
    .direction(direction),
    .evaluated(evaluated)
  );

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_LEN))
    else $error("Fill count ran past the window length.");

  a_pending_result_loads: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("A pending transaction did not reach the output register.");
`endif

endmodule
